// ===== sv/cbc_pkg.sv =====
// Package for the cartridge bank controller: field widths, bus codes,
// address window decode and the cartridge RAM geometry.
// No dependencies.
package cbc_pkg;

  // Field widths of the bus words.
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned ROM_ADDR_W = 18;

  // Bank geometry. A ROM bank is 16 KiB and a RAM bank 8 KiB.
  localparam int unsigned ROM_BANK_BYTES = 16384;
  localparam int unsigned RAM_BANK_BYTES = 8192;
  localparam int unsigned ROM_OFFS_W     = $clog2(ROM_BANK_BYTES);
  localparam int unsigned RAM_OFFS_W     = $clog2(RAM_BANK_BYTES);
  localparam int unsigned ROM_BANK_W     = ROM_ADDR_W - ROM_OFFS_W;
  localparam int unsigned RAM_BANK_W     = 2;
  localparam int unsigned RAM_ADDR_W     = RAM_BANK_W + RAM_OFFS_W;
  localparam int unsigned RAM_DEPTH      = 1 << RAM_ADDR_W;

  // Packed word widths, padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 32;

  // Bus constants.
  localparam logic [DATA_W-1:0]     OPEN_BUS    = 8'hFF;
  localparam logic [3:0]            RAM_EN_KEY  = 4'hA;
  localparam logic [ROM_BANK_W-1:0] ROM_BANK_RST = ROM_BANK_W'(1);

  // Access kind carried in tuser.
  typedef enum logic {
    ACT_READ  = 1'b0,
    ACT_WRITE = 1'b1
  } action_t;

  // The CPU address space seen as eight 8 KiB windows (top three bits).
  typedef enum logic [2:0] {
    WIN_RAM_EN   = 3'd0,  // 0x0000-0x1FFF: RAM enable on write, ROM bank 0 on read
    WIN_BANK_SEL = 3'd1,  // 0x2000-0x3FFF: bank select on write, ROM bank 0 on read
    WIN_ROMX_LO  = 3'd2,  // 0x4000-0x5FFF: switchable ROM
    WIN_MODE     = 3'd3,  // 0x6000-0x7FFF: mode select on write, switchable ROM on read
    WIN_VRAM     = 3'd4,  // 0x8000-0x9FFF: not mapped here
    WIN_CART_RAM = 3'd5,  // 0xA000-0xBFFF: cartridge RAM
    WIN_HI_LO    = 3'd6,  // 0xC000-0xDFFF: not mapped here
    WIN_HI_HI    = 3'd7   // 0xE000-0xFFFF: not mapped here
  } window_t;

endpackage

// ===== sv/cartridge_bank_controller.sv =====
// Cartridge bank controller top level: bank registers, cartridge RAM and
// the one-stage access pipeline. Depends on cbc_pkg.

// Each bus access word entering on the in_ side gives exactly one result word
// on the out_ side in the next cycle, and a new word is taken every cycle while
// the result side keeps up; the single result register, with the synchronous
// read port of the cartridge RAM behind it, sets that rate. After reset the
// block first clears the 32 KiB cartridge RAM, one byte a cycle, and holds
// in_tready low until that pass is done. ROM reads are not served here: the
// result carries rom_fetch (in out_tuser) and the physical ROM byte address
// for an external ROM, with read_data at 0xFF.
module cartridge_bank_controller
  import cbc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Access words
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] address, [23:16] write_data
  input  logic                   in_tuser,   // [0] action (0 read, 1 write)
  // Result words
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] read_data, [25:8] rom_address, rest 0
  output logic                   out_tuser   // [0] rom_fetch
);

  // Unpacked input fields.
  logic [ADDR_W-1:0] in_address;
  logic [DATA_W-1:0] in_write_data;
  action_t           in_action;
  window_t           in_window;

  assign in_address    = in_tdata[ADDR_W-1:0];
  assign in_write_data = in_tdata[ADDR_W +: DATA_W];
  assign in_action     = action_t'(in_tuser);
  assign in_window     = window_t'(in_address[ADDR_W-1 -: 3]);

  // Bank controller state.
  logic                  ram_enable_r,   ram_enable_nxt;
  logic [ROM_BANK_W-1:0] rom_bank_sel_r, rom_bank_sel_nxt;
  logic [RAM_BANK_W-1:0] ram_bank_sel_r, ram_bank_sel_nxt;
  logic                  ram_mode_r,     ram_mode_nxt;

  // RAM clearing pass after reset.
  logic                  clr_busy_r;
  logic [RAM_ADDR_W-1:0] clr_addr_r;

  // Result register.
  logic                  out_valid_r;
  logic                  out_from_ram_r, out_from_ram_nxt;
  logic                  out_fetch_r,    out_fetch_nxt;
  logic [ROM_ADDR_W-1:0] out_rom_addr_r, out_rom_addr_nxt;

  // Cartridge RAM and its registered read data.
  logic [DATA_W-1:0]     cart_ram [RAM_DEPTH];
  logic [DATA_W-1:0]     ram_q_r;
  logic [RAM_ADDR_W-1:0] ram_idx;
  logic                  ram_we;
  logic                  ram_re;

  logic accept;
  logic [3:0] wr_rom_bank;

  // A word is taken when the result register is free or being emptied.
  assign in_tready = !clr_busy_r && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  assign ram_idx     = {ram_bank_sel_r, in_address[RAM_OFFS_W-1:0]};
  assign wr_rom_bank = in_write_data[3:0];

  // Decode of one access: state updates, RAM strobes and result fields.
  always_comb begin
    ram_enable_nxt   = ram_enable_r;
    rom_bank_sel_nxt = rom_bank_sel_r;
    ram_bank_sel_nxt = ram_bank_sel_r;
    ram_mode_nxt     = ram_mode_r;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    out_from_ram_nxt = 1'b0;
    out_fetch_nxt    = 1'b0;
    out_rom_addr_nxt = '0;
    if (in_action == ACT_WRITE) begin
      unique case (in_window) inside
        WIN_RAM_EN: begin
          ram_enable_nxt = (in_write_data[3:0] == RAM_EN_KEY);
        end
        WIN_BANK_SEL: begin
          if (!ram_mode_r) begin
            // Bank 0 cannot be mapped into the switchable window.
            rom_bank_sel_nxt = (wr_rom_bank == '0) ? ROM_BANK_RST
                                                    : wr_rom_bank[ROM_BANK_W-1:0];
          end else begin
            ram_bank_sel_nxt = in_write_data[RAM_BANK_W-1:0];
          end
        end
        WIN_MODE: begin
          ram_mode_nxt = in_write_data[0];
        end
        WIN_CART_RAM: begin
          ram_we = ram_enable_r;
        end
        WIN_ROMX_LO, WIN_VRAM, WIN_HI_LO, WIN_HI_HI: begin
        end
        default: begin
        end
      endcase
    end else begin
      unique case (in_window) inside
        WIN_RAM_EN, WIN_BANK_SEL: begin
          out_fetch_nxt    = 1'b1;
          out_rom_addr_nxt = {ROM_BANK_W'(0), in_address[ROM_OFFS_W-1:0]};
        end
        WIN_ROMX_LO, WIN_MODE: begin
          out_fetch_nxt    = 1'b1;
          out_rom_addr_nxt = {rom_bank_sel_r, in_address[ROM_OFFS_W-1:0]};
        end
        WIN_CART_RAM: begin
          ram_re           = ram_enable_r;
          out_from_ram_nxt = ram_enable_r;
        end
        WIN_VRAM, WIN_HI_LO, WIN_HI_HI: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Control state and the clearing counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_enable_r   <= 1'b0;
      rom_bank_sel_r <= ROM_BANK_RST;
      ram_bank_sel_r <= '0;
      ram_mode_r     <= 1'b0;
      clr_busy_r     <= 1'b1;
      clr_addr_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + RAM_ADDR_W'(1);
        if (clr_addr_r == '1) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (accept) begin
        ram_enable_r   <= ram_enable_nxt;
        rom_bank_sel_r <= rom_bank_sel_nxt;
        ram_bank_sel_r <= ram_bank_sel_nxt;
        ram_mode_r     <= ram_mode_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, loaded on every accepted word.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_from_ram_r <= out_from_ram_nxt;
      out_fetch_r    <= out_fetch_nxt;
      out_rom_addr_r <= out_rom_addr_nxt;
    end
  end

  // Cartridge RAM: one write port shared with the clearing pass, one read port.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      cart_ram[clr_addr_r] <= '0;
    end else if (accept && ram_we) begin
      cart_ram[ram_idx] <= in_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ram_re) begin
      ram_q_r <= cart_ram[ram_idx];
    end
  end

  // Result word packing.
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_fetch_r;
  assign out_tdata  = {(OUT_TDATA_W - ROM_ADDR_W - DATA_W)'(0), out_rom_addr_r,
                       out_from_ram_r ? ram_q_r : OPEN_BUS};

  // No access is taken while the RAM is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_tready)
    else $error("access taken during RAM clearing pass");

  // The switchable ROM window never maps bank 0.
  a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    rom_bank_sel_r != '0)
    else $error("ROM bank select holds zero");

  // Every accepted access yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tvalid)
    else $error("accepted access gave no result");

  // A ROM fetch result carries open-bus read data.
  a_fetch_open_bus: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[DATA_W-1:0] == OPEN_BUS)
    else $error("ROM fetch result with RAM data");

  // Results that are not ROM fetches carry a zero ROM address.
  a_nofetch_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_rom_addr_r == '0)
    else $error("ROM address set on a non-fetch result");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the cartridge bank controller: bus access words
// in, result words checked against a bank and RAM predictor in a scoreboard.
// Depends on cbc_pkg and cartridge_bank_controller.
module tb
  import cbc_pkg::*;
();

  localparam int unsigned RANDOM_ACCESSES = 400;
  localparam int unsigned WATCHDOG_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES    = 16;

  // One expected result word, split into its fields.
  typedef struct packed {
    logic [DATA_W-1:0]     read_data;
    logic                  rom_fetch;
    logic [ROM_ADDR_W-1:0] rom_address;
  } bus_result_t;

  // Scoreboard: mirrors the bank registers and cartridge RAM, and holds the
  // results still owed by the block, oldest first.
  class access_scoreboard;
    logic                  ram_enabled;
    logic [ROM_BANK_W-1:0] rom_bank;
    logic [RAM_BANK_W-1:0] ram_bank;
    logic                  ram_mode;
    logic [DATA_W-1:0]     cart_ram [RAM_DEPTH];
    bus_result_t           owed [$];
    int unsigned           errors;
    int unsigned           rom_fetches;
    int unsigned           ram_hits;

    function new();
      ram_enabled = 1'b0;
      rom_bank    = ROM_BANK_RST;
      ram_bank    = '0;
      ram_mode    = 1'b0;
      errors      = 0;
      rom_fetches = 0;
      ram_hits    = 0;
      foreach (cart_ram[i]) cart_ram[i] = '0;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    // Applies one accepted access to the mirrored state and queues its result.
    function void note_access(action_t act, logic [ADDR_W-1:0] addr,
                              logic [DATA_W-1:0] wdata);
      bus_result_t           res;
      window_t               win;
      logic [RAM_ADDR_W-1:0] ram_idx;
      res.read_data   = OPEN_BUS;
      res.rom_fetch   = 1'b0;
      res.rom_address = '0;
      win     = window_t'(addr[ADDR_W-1:ADDR_W-3]);
      ram_idx = {ram_bank, addr[RAM_OFFS_W-1:0]};
      if (act == ACT_WRITE) begin
        case (win)
          WIN_RAM_EN: begin
            ram_enabled = (wdata[3:0] == RAM_EN_KEY);
          end
          WIN_BANK_SEL: begin
            // ROM banking mode selects the ROM bank, with bank 0 mapped to 1.
            if (!ram_mode) begin
              rom_bank = (wdata[3:0] == '0) ? ROM_BANK_RST : wdata[3:0];
            end else begin
              ram_bank = wdata[RAM_BANK_W-1:0];
            end
          end
          WIN_MODE: begin
            ram_mode = wdata[0];
          end
          WIN_CART_RAM: begin
            if (ram_enabled) cart_ram[ram_idx] = wdata;
          end
          default: begin
          end
        endcase
      end else begin
        case (win) inside
          WIN_RAM_EN, WIN_BANK_SEL: begin
            res.rom_fetch   = 1'b1;
            res.rom_address = ROM_ADDR_W'(addr);
          end
          WIN_ROMX_LO, WIN_MODE: begin
            res.rom_fetch   = 1'b1;
            res.rom_address = {rom_bank, addr[ROM_OFFS_W-1:0]};
          end
          WIN_CART_RAM: begin
            if (ram_enabled) begin
              res.read_data = cart_ram[ram_idx];
              ram_hits++;
            end
          end
          default: begin
          end
        endcase
      end
      if (res.rom_fetch) rom_fetches++;
      owed.push_back(res);
    endfunction

    // Compares one accepted result word with the oldest owed result.
    function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic tuser);
      bus_result_t want;
      if (owed.size() == 0) begin
        $error("unexpected result word: tdata %h tuser %b", tdata, tuser);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (tdata[DATA_W-1:0] !== want.read_data) begin
        $error("read_data: expected %h, got %h", want.read_data, tdata[DATA_W-1:0]);
        errors++;
      end
      if (tdata[DATA_W+ROM_ADDR_W-1:DATA_W] !== want.rom_address) begin
        $error("rom_address: expected %h, got %h", want.rom_address,
               tdata[DATA_W+ROM_ADDR_W-1:DATA_W]);
        errors++;
      end
      if (tuser !== want.rom_fetch) begin
        $error("rom_fetch: expected %b, got %b", want.rom_fetch, tuser);
        errors++;
      end
      if (tdata[OUT_TDATA_W-1:DATA_W+ROM_ADDR_W] !== '0) begin
        $error("padding: expected 0, got %h", tdata[OUT_TDATA_W-1:DATA_W+ROM_ADDR_W]);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  access_scoreboard sb = new();
  bit               calm = 1'b0;
  int unsigned      quiet_cycles = 0;
  int unsigned      n_reads = 0;
  int unsigned      n_writes = 0;

  cartridge_bank_controller uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Result side: check each accepted word, then stall at random.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    out_tready <= calm || ($urandom_range(99) >= 9);
  end

  // Count cycles in which neither side moves a word.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: the RAM clear after reset is the longest quiet spell expected.
  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // Offers one access word, with a random gap first, and waits for acceptance.
  task automatic send_access(input action_t act, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] wdata);
    while (!calm && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {wdata, addr};
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
    sb.note_access(act, addr, wdata);
    if (act == ACT_WRITE) n_writes++;
    else n_reads++;
  endtask

  // Holds the sender back until every owed result has arrived.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Offset into the cartridge RAM window, often from a small set so that
  // reads land on bytes written earlier.
  function automatic logic [ADDR_W-1:0] ram_window_addr();
    logic [RAM_OFFS_W-1:0] offs;
    offs = ($urandom_range(1) == 0) ? RAM_OFFS_W'($urandom_range(15))
                                    : RAM_OFFS_W'($urandom_range(8191));
    return 16'hA000 | ADDR_W'(offs);
  endfunction

  // One random access, weighted towards register writes and RAM traffic.
  task automatic send_random_access();
    int unsigned       pick;
    logic [DATA_W-1:0] wdata;
    pick  = $urandom_range(99);
    wdata = DATA_W'($urandom_range(255));
    if (pick < 8) begin
      // Mostly the enable key in the low nibble, so RAM is usually on.
      if ($urandom_range(9) < 7) wdata[3:0] = RAM_EN_KEY;
      send_access(ACT_WRITE, ADDR_W'($urandom_range(16'h1FFF)), wdata);
    end else if (pick < 16) begin
      send_access(ACT_WRITE, ADDR_W'($urandom_range(16'h3FFF, 16'h2000)), wdata);
    end else if (pick < 22) begin
      send_access(ACT_WRITE, ADDR_W'($urandom_range(16'h7FFF, 16'h6000)), wdata);
    end else if (pick < 42) begin
      send_access(ACT_WRITE, ram_window_addr(), wdata);
    end else if (pick < 62) begin
      send_access(ACT_READ, ram_window_addr(), wdata);
    end else if (pick < 80) begin
      send_access(ACT_READ, ADDR_W'($urandom_range(16'h7FFF)), wdata);
    end else begin
      send_access(action_t'($urandom_range(1)), ADDR_W'($urandom_range(16'hFFFF)), wdata);
    end
  endtask

  initial begin
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= ACT_READ;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: ROM windows at both ends, RAM disabled and enabled,
    // bank 0 forced to 1, the top ROM bank, RAM banking mode and unmapped space.
    send_access(ACT_READ,  16'h0000, 8'h00);
    send_access(ACT_READ,  16'h3FFF, 8'hFF);
    send_access(ACT_READ,  16'h4000, 8'h00);
    send_access(ACT_READ,  16'hA000, 8'h00);
    send_access(ACT_WRITE, 16'hA000, 8'h55);
    send_access(ACT_WRITE, 16'h0000, 8'h0A);
    send_access(ACT_READ,  16'hA000, 8'h00);
    send_access(ACT_WRITE, 16'hA000, 8'hFF);
    send_access(ACT_WRITE, 16'hBFFF, 8'h81);
    send_access(ACT_READ,  16'hBFFF, 8'h00);
    send_access(ACT_WRITE, 16'h2000, 8'h00);
    send_access(ACT_READ,  16'h7FFF, 8'h00);
    send_access(ACT_WRITE, 16'h3FFF, 8'hFF);
    send_access(ACT_READ,  16'h7FFF, 8'h00);
    send_access(ACT_WRITE, 16'h6000, 8'h01);
    send_access(ACT_WRITE, 16'h2000, 8'h03);
    send_access(ACT_WRITE, 16'hBFFF, 8'h3C);
    send_access(ACT_READ,  16'hBFFF, 8'h00);
    send_access(ACT_READ,  16'h4000, 8'h00);
    send_access(ACT_WRITE, 16'h7FFF, 8'hFE);
    send_access(ACT_WRITE, 16'h4000, 8'h12);
    send_access(ACT_READ,  16'h8000, 8'h00);
    send_access(ACT_READ,  16'hFFFF, 8'h00);
    send_access(ACT_WRITE, 16'h1FFF, 8'hFB);
    send_access(ACT_READ,  16'hA000, 8'h00);
    drain_results();

    // Random part, with a stretch free of idling on both sides and one more
    // pause for every owed result part way through.
    for (int unsigned n = 0; n < RANDOM_ACCESSES; n++) begin
      calm = (n >= 150 && n < 250);
      if (n == 300) drain_results();
      send_random_access();
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d accesses checked (%0d reads, %0d writes)", n_reads + n_writes,
             n_reads, n_writes);
    $display("tb: %0d ROM fetch addresses and %0d enabled RAM reads among them",
             sb.rom_fetches, sb.ram_hits);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
